### src/ffba_pkg.sv
package ffba_pkg;

   localparam int ID_W    = 8;
   localparam int NEED_W  = 7;
   localparam int START_W = 6;

   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   typedef struct packed {
      logic              cmd;
      logic [ID_W-1:0]   proc_id;
      logic [NEED_W-1:0] req_blocks;
   } req_type;

   typedef struct packed {
      logic               ok;
      logic [START_W-1:0] start_block;
      logic               compacted;
   } rsp_type;

   // one map entry: free flag and owner id (owner meaningful only when not free)
   typedef struct packed {
      logic            free;
      logic [ID_W-1:0] owner;
   } entry_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_FREE,
      ST_SRCH,
      ST_MARK,
      ST_CMPT,
      ST_FILL,
      ST_RESP
   } state_type;

endpackage

### src/ffba_map.sv
module ffba_map #(
   parameter int DEPTH = 64,
   parameter int AW    = 6
) (
   input  logic                clock,
   input  logic                we,
   input  logic [AW-1:0]       waddr,
   input  ffba_pkg::entry_type wdata,
   input  logic [AW-1:0]       raddr,
   output ffba_pkg::entry_type rdata
);
   import ffba_pkg::*;

   entry_type mem_ff [DEPTH];
   entry_type rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

### src/first_fit_block_allocator_top.sv
// Channel   Dir  Handshake            Payload
// req_      in   req_valid/req_stall  cmd, proc_id, req_blocks
// rsp_      out  rsp_valid/rsp_stall  ok, start_block, compacted
//
// One item at a time; the map memory is read one block per cycle through a
// single read port during the free, search and compaction scans.
// Free: one scan releases the caller's blocks. Allocate: a first-fit search,
// then a mark pass on a hit; on a miss, compaction and a fill pass, then a
// second search (fill pass shrinks as blocks are owned).
// After reset a clearing pass marks every block free; req_stall
// stays high until it ends. The result waits in an output register, so a
// stalled rsp_ only delays the hand-off of the next finished item.
module first_fit_block_allocator_top #(
   parameter int NUM_BLOCKS = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  ffba_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output ffba_pkg::rsp_type rsp_data
);
   import ffba_pkg::*;

   localparam int AW = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
   localparam int CW = $clog2(NUM_BLOCKS + 1);
   localparam int LW = (CW > NEED_W) ? CW : NEED_W;
   localparam logic [AW-1:0] LAST  = AW'(NUM_BLOCKS - 1);
   localparam logic [CW-1:0] NBLKS = CW'(NUM_BLOCKS);

   state_type state_ff, state_in;

   // scan engine: read issue index, returned-data index and flags
   logic [AW-1:0]     idx_ff, idx_in;
   logic              iss_ff, iss_in;
   logic              dv_ff, dv_in;
   logic [AW-1:0]     didx_ff, didx_in;
   // run counter and start / compaction write pointer / mark pointer and count
   logic [CW-1:0]     run_ff, run_in;
   logic [AW-1:0]     first_ff, first_in;
   logic [CW-1:0]     wptr_ff, wptr_in;
   logic [AW-1:0]     mptr_ff, mptr_in;
   logic [CW-1:0]     mcnt_ff, mcnt_in;
   // item being worked on
   logic              cmd_ff, cmd_in;
   logic [ID_W-1:0]   id_ff, id_in;
   logic [NEED_W-1:0] need_ff, need_in;
   logic              cmp_ff, cmp_in;
   logic              ok_ff, ok_in;
   logic [AW-1:0]     start_ff, start_in;
   // output register
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   // map port
   logic              we;
   logic [AW-1:0]     waddr;
   entry_type         wdata;
   entry_type         rdata;

   logic              scan_end;
   logic [CW-1:0]     run_next;
   logic              hit;
   logic              rsp_load;

   ffba_map #(.DEPTH(NUM_BLOCKS), .AW(AW)) u_map (
      .clock (clock),
      .we    (we),
      .waddr (waddr),
      .wdata (wdata),
      .raddr (idx_ff),
      .rdata (rdata)
   );

   assign scan_end = !iss_ff && !dv_ff;
   assign run_next = run_ff + 1'b1;
   assign hit      = (state_ff == ST_SRCH) && dv_ff && rdata.free &&
                     (LW'(run_next) == LW'(need_ff));
   assign rsp_load = !rsp_valid_ff || !rsp_stall;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (idx_ff == LAST) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) state_in = (req_data.cmd == CMD_FREE) ? ST_FREE : ST_SRCH;
         end
         ST_FREE: begin
            if (scan_end) state_in = ST_RESP;
         end
         ST_SRCH: begin
            if (hit) state_in = ST_MARK;
            else if (scan_end) state_in = cmp_ff ? ST_RESP : ST_CMPT;
         end
         ST_MARK: begin
            if (mcnt_ff == CW'(1)) state_in = ST_RESP;
         end
         ST_CMPT: begin
            if (scan_end) state_in = ST_FILL;
         end
         ST_FILL: begin
            if (wptr_ff == NBLKS) state_in = ST_SRCH;
         end
         ST_RESP: begin
            if (rsp_load) state_in = ST_IDLE;
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   // datapath and map writes
   always_comb begin
      idx_in       = idx_ff;
      iss_in       = iss_ff;
      dv_in        = 1'b0;
      didx_in      = idx_ff;
      run_in       = run_ff;
      first_in     = first_ff;
      wptr_in      = wptr_ff;
      mptr_in      = mptr_ff;
      mcnt_in      = mcnt_ff;
      cmd_in       = cmd_ff;
      id_in        = id_ff;
      need_in      = need_ff;
      cmp_in       = cmp_ff;
      ok_in        = ok_ff;
      start_in     = start_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      we           = 1'b0;
      waddr        = idx_ff;
      wdata.free   = 1'b1;
      wdata.owner  = id_ff;

      // read issue for every scanning state
      if (state_ff == ST_FREE || state_ff == ST_SRCH || state_ff == ST_CMPT) begin
         dv_in = iss_ff;
         if (iss_ff) begin
            if (idx_ff == LAST) iss_in = 1'b0;
            else idx_in = idx_ff + 1'b1;
         end
      end

      case (state_ff)
         ST_CLEAR: begin
            we     = 1'b1;
            waddr  = idx_ff;
            idx_in = idx_ff + 1'b1;
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd_in   = req_data.cmd;
               id_in    = req_data.proc_id;
               need_in  = req_data.req_blocks;
               cmp_in   = 1'b0;
               ok_in    = (req_data.cmd == CMD_FREE);
               start_in = '0;
               idx_in   = '0;
               iss_in   = 1'b1;
               run_in   = '0;
            end
         end
         ST_FREE: begin
            if (dv_ff && !rdata.free && rdata.owner == id_ff) begin
               we          = 1'b1;
               waddr       = didx_ff;
               wdata.free  = 1'b1;
               wdata.owner = rdata.owner;
            end
         end
         ST_SRCH: begin
            if (dv_ff) begin
               if (rdata.free) begin
                  if (run_ff == '0) first_in = didx_ff;
                  run_in = run_next;
                  if (hit) begin
                     iss_in   = 1'b0;
                     dv_in    = 1'b0;
                     mptr_in  = (run_ff == '0) ? didx_ff : first_ff;
                     start_in = (run_ff == '0) ? didx_ff : first_ff;
                     mcnt_in  = run_next;
                     ok_in    = 1'b1;
                  end
               end else begin
                  run_in = '0;
               end
            end else if (scan_end && !cmp_ff) begin
               cmp_in  = 1'b1;
               idx_in  = '0;
               iss_in  = 1'b1;
               wptr_in = '0;
            end
         end
         ST_MARK: begin
            we          = 1'b1;
            waddr       = mptr_ff;
            wdata.free  = 1'b0;
            wdata.owner = id_ff;
            mptr_in     = mptr_ff + 1'b1;
            mcnt_in     = mcnt_ff - 1'b1;
         end
         ST_CMPT: begin
            // owned blocks slide down to the write pointer, order kept
            if (dv_ff && !rdata.free) begin
               we          = 1'b1;
               waddr       = wptr_ff[AW-1:0];
               wdata.free  = 1'b0;
               wdata.owner = rdata.owner;
               wptr_in     = wptr_ff + 1'b1;
            end
         end
         ST_FILL: begin
            if (wptr_ff != NBLKS) begin
               we      = 1'b1;
               waddr   = wptr_ff[AW-1:0];
               wptr_in = wptr_ff + 1'b1;
            end else begin
               idx_in = '0;
               iss_in = 1'b1;
               run_in = '0;
            end
         end
         ST_RESP: begin
            if (rsp_load) begin
               rsp_valid_in       = 1'b1;
               rsp_in.ok          = ok_ff;
               rsp_in.start_block = ok_ff ? START_W'(start_ff) : '0;
               rsp_in.compacted   = cmp_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         idx_ff       <= '0;
         iss_ff       <= 1'b0;
         dv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         iss_ff       <= iss_in;
         dv_ff        <= dv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      didx_ff  <= didx_in;
      run_ff   <= run_in;
      first_ff <= first_in;
      wptr_ff  <= wptr_in;
      mptr_ff  <= mptr_in;
      mcnt_ff  <= mcnt_in;
      cmd_ff   <= cmd_in;
      id_ff    <= id_in;
      need_ff  <= need_in;
      cmp_ff   <= cmp_in;
      ok_ff    <= ok_in;
      start_ff <= start_in;
      rsp_ff   <= rsp_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // an accepted item blocks the input until its result is in the output register
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input not stalled after accept");

   // a new result only comes from the result state
   a_rsp_from_resp: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff == ST_RESP))
      else $error("result raised outside result state");

   // compaction never writes ahead of the block being read
   a_cmpt_order: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CMPT && dv_ff |-> wptr_ff <= CW'(didx_ff))
      else $error("compaction write pointer passed read index");

   // mark phase always has at least one block left to claim
   a_mark_count: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_MARK |-> mcnt_ff != '0)
      else $error("mark phase with empty count");

   // free command results never report compaction
   a_free_no_cmp: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_RESP && cmd_ff == CMD_FREE |-> ok_ff && !cmp_ff)
      else $error("free result with wrong flags");

endmodule
